@@ rtl/core/lsi_pkg.sv @@
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared types and constants of the laser safety interlock.
// ----------------------------------------------------------------------------
package lsi_pkg;

    // command codes
    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_ON        = 3'd1,
        OP_OFF       = 3'd2,
        OP_ARM       = 3'd3,
        OP_DISARM    = 3'd4,
        OP_KILL      = 3'd5,
        OP_RESET_KILL = 3'd6,
        OP_READ_STAT = 3'd7
    } opcode_t;

    // interlock modes
    typedef enum logic [2:0] {
        MODE_OFF      = 3'd0,
        MODE_ARMED    = 3'd1,
        MODE_ACTIVE   = 3'd2,
        MODE_COOLDOWN = 3'd3,
        MODE_ESTOP    = 3'd4
    } mode_t;

    // turn-on status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_KILLED   = 2'd1,
        STATUS_UNARMED  = 2'd2,
        STATUS_COOLDOWN = 2'd3
    } status_t;

    // statistic selectors
    localparam logic [2:0] STAT_ACTIVATIONS = 3'd0;
    localparam logic [2:0] STAT_TIMEOUTS    = 3'd1;
    localparam logic [2:0] STAT_BLOCKS      = 3'd2;
    localparam logic [2:0] STAT_KILLS       = 3'd3;
    localparam logic [2:0] STAT_TOTAL_ON    = 3'd4;
    localparam logic [2:0] STAT_LAST_ON     = 3'd5;
    localparam logic [2:0] STAT_UPTIME      = 3'd6;

    // configuration register indexes
    localparam logic CFG_MAX_ON   = 1'b0;
    localparam logic CFG_COOLDOWN = 1'b1;

    localparam logic [15:0] MAX_ON_RESET   = 16'd10000;
    localparam logic [15:0] COOLDOWN_RESET = 16'd5000;

    localparam int DATA_IN_W  = 8;
    localparam int DATA_OUT_W = 112;

    // interlock state
    typedef struct packed {
        mode_t       mode;
        logic        laser;
        logic        armed;
        logic        kill;
        logic [15:0] on_timer;
        logic [15:0] cd_timer;
        logic [31:0] cnt_activ;
        logic [31:0] cnt_timeout;
        logic [31:0] cnt_block;
        logic [31:0] cnt_kill;
        logic [31:0] total_on;
        logic [47:0] last_stamp;
        logic [47:0] uptime;
    } lsi_state_t;

    // one result item
    typedef struct packed {
        logic [47:0] stat_value;
        logic        timeout_fired;
        logic [15:0] on_left;
        logic [15:0] on_elapsed;
        logic [15:0] cooldown_left;
        logic        kill_engaged;
        logic        is_armed;
        logic        laser_enable;
        mode_t       mode;
        status_t     status;
    } lsi_result_t;

endpackage

@@ rtl/core/lsi_step.sv @@
// ----------------------------------------------------------------------------
// lsi_step
// Next state and result of one command, applied to the current state.
// ----------------------------------------------------------------------------
module lsi_step (
    input  lsi_pkg::lsi_state_t  cur,
    input  logic [2:0]           opcode,
    input  logic [2:0]           stat_index,
    input  logic [15:0]          max_on_ms,
    input  logic [15:0]          cooldown_ms,
    output lsi_pkg::lsi_state_t  nxt,
    output lsi_pkg::lsi_result_t res
);
    import lsi_pkg::*;

    always_comb
    begin
        lsi_state_t  s;
        status_t     status;
        logic        fired;
        logic [47:0] stat;

        s      = cur;
        status = STATUS_OK;
        fired  = 1'b0;
        stat   = '0;

        case (opcode_t'(opcode))
            OP_TICK:
            begin
                s.uptime = cur.uptime + 48'd1;
                if (cur.cd_timer != 16'd0)
                begin
                    s.cd_timer = cur.cd_timer - 16'd1;
                end
                if (cur.laser)
                begin
                    if (cur.on_timer != 16'hFFFF)
                    begin
                        s.on_timer = cur.on_timer + 16'd1;
                    end
                    // on-time limit reached: forced shutoff
                    if (s.on_timer >= max_on_ms)
                    begin
                        s.total_on    = cur.total_on + {16'd0, s.on_timer};
                        s.laser       = 1'b0;
                        s.on_timer    = '0;
                        s.cd_timer    = cooldown_ms;
                        s.cnt_timeout = cur.cnt_timeout + 32'd1;
                        s.mode        = MODE_COOLDOWN;
                        fired         = 1'b1;
                    end
                end
                // leave cooldown once the timer ran out
                if (s.mode == MODE_COOLDOWN && s.cd_timer == 16'd0)
                begin
                    if (s.armed && !s.kill)
                        s.mode = MODE_ARMED;
                    else
                        s.mode = s.kill ? MODE_ESTOP : MODE_OFF;
                end
            end
            OP_ON:
            begin
                if (cur.kill)
                begin
                    status = STATUS_KILLED;
                end
                else if (!cur.armed)
                begin
                    status = STATUS_UNARMED;
                end
                else if (cur.cd_timer != 16'd0)
                begin
                    status      = STATUS_COOLDOWN;
                    s.cnt_block = cur.cnt_block + 32'd1;
                end
                else if (!cur.laser)
                begin
                    s.laser      = 1'b1;
                    s.on_timer   = '0;
                    s.last_stamp = cur.uptime;
                    s.cnt_activ  = cur.cnt_activ + 32'd1;
                    s.mode       = MODE_ACTIVE;
                end
            end
            OP_OFF:
            begin
                if (cur.laser)
                begin
                    s.total_on = cur.total_on + {16'd0, cur.on_timer};
                    s.laser    = 1'b0;
                    s.on_timer = '0;
                    s.cd_timer = cooldown_ms;
                    if (cur.armed && !cur.kill)
                        s.mode = MODE_COOLDOWN;
                    else
                        s.mode = cur.kill ? MODE_ESTOP : MODE_OFF;
                end
            end
            OP_ARM:
            begin
                if (!cur.kill && !cur.armed)
                begin
                    s.armed = 1'b1;
                    s.mode  = MODE_ARMED;
                end
            end
            OP_DISARM:
            begin
                if (cur.laser)
                begin
                    s.total_on = cur.total_on + {16'd0, cur.on_timer};
                    s.laser    = 1'b0;
                    s.on_timer = '0;
                    s.cd_timer = cooldown_ms;
                end
                s.armed = 1'b0;
                s.mode  = MODE_OFF;
            end
            OP_KILL:
            begin
                if (cur.laser)
                begin
                    s.total_on = cur.total_on + {16'd0, cur.on_timer};
                    s.laser    = 1'b0;
                    s.on_timer = '0;
                    s.cd_timer = cooldown_ms;
                end
                s.kill     = 1'b1;
                s.armed    = 1'b0;
                s.cnt_kill = cur.cnt_kill + 32'd1;
                s.mode     = MODE_ESTOP;
            end
            OP_RESET_KILL:
            begin
                if (cur.kill)
                begin
                    s.kill = 1'b0;
                    s.mode = MODE_OFF;
                end
            end
            default:
            begin
                case (stat_index)
                    STAT_ACTIVATIONS: stat = {16'd0, cur.cnt_activ};
                    STAT_TIMEOUTS:    stat = {16'd0, cur.cnt_timeout};
                    STAT_BLOCKS:      stat = {16'd0, cur.cnt_block};
                    STAT_KILLS:       stat = {16'd0, cur.cnt_kill};
                    STAT_TOTAL_ON:    stat = {16'd0, cur.total_on};
                    STAT_LAST_ON:     stat = cur.last_stamp;
                    STAT_UPTIME:      stat = cur.uptime;
                    default:          stat = '0;
                endcase
            end
        endcase

        nxt = s;

        // result fields from the updated state
        res.status        = status;
        res.mode          = s.mode;
        res.laser_enable  = s.laser;
        res.is_armed      = s.armed;
        res.kill_engaged  = s.kill;
        res.cooldown_left = s.cd_timer;
        res.on_elapsed    = s.laser ? s.on_timer : 16'd0;
        res.on_left       = (s.laser && s.on_timer < max_on_ms)
                            ? (max_on_ms - s.on_timer) : 16'd0;
        res.timeout_fired = fired;
        res.stat_value    = stat;
    end

endmodule

@@ rtl/core/lsi_out_buf.sv @@
// ----------------------------------------------------------------------------
// lsi_out_buf
// Result register with a skid stage, so the upstream side sees a
// registered ready and a new beat can enter while a result waits.
// ----------------------------------------------------------------------------
module lsi_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lsi_pkg::lsi_result_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lsi_pkg::lsi_result_t out_data
);
    import lsi_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    lsi_result_t out_reg;
    lsi_result_t skid_reg;
    logic        in_fire;
    logic        out_free;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // valid bookkeeping
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || in_fire;
            skid_valid_next = 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload: skid drains first, otherwise the incoming beat
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_fire)
                out_reg <= in_data;
        end
        else if (in_fire)
        begin
            skid_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ rtl/core/laser_safety_interlock.sv @@
// ----------------------------------------------------------------------------
// laser_safety_interlock
// Opcode-driven laser safety interlock with on-time limit, cooldown and
// event statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis group (opcode, stat_index), one beat per
//   command; each command gives exactly one result beat on m_axis with the
//   interlock status after the command. Time advances only with tick
//   commands (one millisecond each).
//   A command is applied to the state registers at the edge that accepts it
//   and its result is registered there, in the skid stage if the receiver
//   stalls. Throughput is one command per cycle while the receiver keeps up;
//   the state update is one pass of compare and counter logic in lsi_step.
//   The result register is backed by a one-entry skid stage: when the
//   receiver stalls, one more command is still taken, then s_axis_tready
//   drops until the result register drains.
//   max_on_ms and cooldown_ms must be written through cfg_we/cfg_addr/
//   cfg_wdata while no command is in flight; the block does not enforce it.
//   Reset (rst_n low) clears all state and counters, loads max_on_ms = 10000
//   and cooldown_ms = 5000, and empties the output side.
// ----------------------------------------------------------------------------
module laser_safety_interlock (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_addr,
    input  logic [15:0]                    cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [2:0] opcode, [5:3] stat_index, [7:6] zero
    input  logic [lsi_pkg::DATA_IN_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] status, [4:2] mode, [5] laser_enable, [6] is_armed,
    // [7] kill_engaged, [23:8] cooldown_left, [39:24] on_elapsed,
    // [55:40] on_left, [56] timeout_fired, [104:57] stat_value, [111:105] zero
    output logic [lsi_pkg::DATA_OUT_W-1:0] m_axis_tdata
);
    import lsi_pkg::*;

    logic [15:0] max_on_reg;
    logic [15:0] cooldown_reg;
    lsi_state_t  state_reg;
    lsi_state_t  state_next;
    lsi_result_t step_res;
    lsi_result_t out_res;
    logic        in_fire;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_on_reg   <= MAX_ON_RESET;
            cooldown_reg <= COOLDOWN_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_MAX_ON)
                max_on_reg <= cfg_wdata;
            else
                cooldown_reg <= cfg_wdata;
        end
    end

    // command step
    lsi_step u_step (
        .cur         (state_reg),
        .opcode      (s_axis_tdata[2:0]),
        .stat_index  (s_axis_tdata[5:3]),
        .max_on_ms   (max_on_reg),
        .cooldown_ms (cooldown_reg),
        .nxt         (state_next),
        .res         (step_res)
    );

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // interlock state, all zero at reset (mode off)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register and skid stage
    lsi_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (step_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    // result packing
    assign m_axis_tdata = {7'd0, out_res.stat_value, out_res.timeout_fired,
                           out_res.on_left, out_res.on_elapsed,
                           out_res.cooldown_left, out_res.kill_engaged,
                           out_res.is_armed, out_res.laser_enable,
                           out_res.mode, out_res.status};

    // laser drive only ever runs in active mode
    a_laser_active: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.laser |-> state_reg.mode == MODE_ACTIVE)
        else $error("laser on outside active mode");

    // kill latch and armed flag never both set
    a_kill_unarmed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.kill |-> !state_reg.armed)
        else $error("armed while kill engaged");

    // a full skid stage implies a pending result
    a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // a forced shutoff leaves the laser off
    a_timeout_off: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res.timeout_fired) |-> !out_res.laser_enable)
        else $error("timeout result with laser on");

    // a tick advances uptime by one
    a_uptime: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tdata[2:0] == OP_TICK) |=>
            state_reg.uptime == $past(state_reg.uptime) + 48'd1)
        else $error("uptime did not advance on tick");

endmodule
